// ===== design/cpc_pkg.sv =====
// Shared types, mode codes and arithmetic helpers for the cursor pixel compositor.
`default_nettype none

package cpc_pkg;

    typedef logic [23:0] t_rgb;
    typedef logic [31:0] t_argb;
    typedef logic [7:0]  t_chan;
    typedef logic [1:0]  t_mode;

    // Cursor shape modes
    localparam t_mode MODE_MONO      = 2'd0;
    localparam t_mode MODE_MASKED    = 2'd1;
    localparam t_mode MODE_BLEND     = 2'd2;
    localparam t_mode MODE_BLEND_ALT = 2'd3;

    localparam t_mode MODE_RESET = MODE_BLEND;

    localparam t_chan       ALPHA_MAX  = 8'd255;
    localparam logic [15:0] ROUND_BIAS = 16'd127;

    // Exact x / 255 for x below 65280
    function automatic t_chan div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + 16'd1 + {8'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== design/cpc_chan_mix.sv =====
// One color channel of the alpha blend: registered weighted sum, then divide by 255.
`default_nettype none

module cpc_chan_mix (
    input  wire logic          i_clk,
    input  wire cpc_pkg::t_chan i_fg,
    input  wire cpc_pkg::t_chan i_bg,
    input  wire cpc_pkg::t_chan i_alpha,
    output cpc_pkg::t_chan     o_chan
);
    import cpc_pkg::*;

    logic [15:0] w_fg_prod;
    logic [15:0] w_bg_prod;
    logic [15:0] n_sum;
    logic [15:0] r_sum;

    // Form fg*a + bg*(255-a) + bias; the total stays below 2^16
    assign w_fg_prod = 16'(i_fg) * 16'(i_alpha);
    assign w_bg_prod = 16'(i_bg) * 16'(ALPHA_MAX - i_alpha);
    assign n_sum     = w_fg_prod + w_bg_prod + ROUND_BIAS;

    // Hold the sum for the next stage
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // Divide by 255 with the add-and-shift identity
    assign o_chan = div255(r_sum);

endmodule

`default_nettype wire

// ===== design/cursor_pixel_compositor_core.sv =====
// Top level of the cursor pixel compositor: input, mix and result register stages.
// Path: an accepted transaction passes the input, stage-1 and result registers
//   before its result shows with o_result_valid high.
// Throughput: one transaction per clock; busy stays low, and the receiver cannot stall.
// Reset: synchronous active-low i_rst_n clears the stage valid bits and sets shape mode
//   to alpha blend; configuration writes are always ready.
`default_nettype none

module cursor_pixel_compositor_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire cpc_pkg::t_rgb  i_desktop_rgb,
    input  wire cpc_pkg::t_argb i_pointer_pixel,
    input  wire logic           i_and_bit,
    input  wire logic           i_xor_bit,
    output logic                o_result_valid,
    output cpc_pkg::t_rgb       o_composed_rgb,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire cpc_pkg::t_mode i_cfg_data
);
    import cpc_pkg::*;

    logic  w_accept;
    t_mode r_shape_mode;

    logic  r_in_valid;
    t_rgb  r_in_desk;
    t_argb r_in_ptr;
    logic  r_in_and;
    logic  r_in_xor;

    logic  r_s1_valid;
    logic  r_s1_blend;
    t_rgb  r_s1_alt;
    t_rgb  n_s1_alt;
    logic  n_s1_blend;

    t_chan w_red;
    t_chan w_green;
    t_chan w_blue;

    logic  r_out_valid;
    t_rgb  r_out_rgb;
    t_rgb  n_out_rgb;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Write the shape mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode <= MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_shape_mode <= i_cfg_data;
        end
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_desk <= i_desktop_rgb;
            r_in_ptr  <= i_pointer_pixel;
            r_in_and  <= i_and_bit;
            r_in_xor  <= i_xor_bit;
        end
    end

    // Decode the mode and form the mask-based results
    always_comb begin
        n_s1_blend = 1'b0;
        n_s1_alt   = '0;
        unique case (r_shape_mode) inside
            MODE_MONO: begin
                n_s1_alt = (r_in_desk & {24{r_in_and}}) ^ {24{r_in_xor}};
            end
            MODE_MASKED: begin
                if (r_in_ptr[31:24] == 8'd0) begin
                    n_s1_alt = r_in_ptr[23:0];
                end else begin
                    n_s1_alt = r_in_desk ^ r_in_ptr[23:0];
                end
            end
            MODE_BLEND, MODE_BLEND_ALT: begin
                n_s1_blend = 1'b1;
            end
            default: begin
                n_s1_blend = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_blend <= n_s1_blend;
        r_s1_alt   <= n_s1_alt;
    end

    // Blend each channel by the pointer alpha
    cpc_chan_mix u_mix_red (
        .i_clk   (i_clk),
        .i_fg    (r_in_ptr[23:16]),
        .i_bg    (r_in_desk[23:16]),
        .i_alpha (r_in_ptr[31:24]),
        .o_chan  (w_red)
    );

    cpc_chan_mix u_mix_green (
        .i_clk   (i_clk),
        .i_fg    (r_in_ptr[15:8]),
        .i_bg    (r_in_desk[15:8]),
        .i_alpha (r_in_ptr[31:24]),
        .o_chan  (w_green)
    );

    cpc_chan_mix u_mix_blue (
        .i_clk   (i_clk),
        .i_fg    (r_in_ptr[7:0]),
        .i_bg    (r_in_desk[7:0]),
        .i_alpha (r_in_ptr[31:24]),
        .o_chan  (w_blue)
    );

    // Select and register the result
    assign n_out_rgb = r_s1_blend ? {w_red, w_green, w_blue} : r_s1_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rgb <= n_out_rgb;
    end

    assign o_result_valid = r_out_valid;
    assign o_composed_rgb = r_out_rgb;

    // Every accepted transaction yields a strobe from the result register
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##2 o_result_valid)
        else $error("accepted transaction produced no result");

    // No strobe without an earlier accepted transaction
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_accept, 3))
        else $error("result strobe without accepted transaction");

    // Masked mode with zero alpha passes the pointer RGB through
    a_masked_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_shape_mode == MODE_MASKED && i_pointer_pixel[31:24] == 8'd0)
        |=> ##2 (o_composed_rgb == $past(i_pointer_pixel[23:0], 3)))
        else $error("masked mode zero alpha did not replace pixel");

    // Full alpha blend returns the pointer RGB
    a_blend_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_shape_mode == MODE_BLEND || r_shape_mode == MODE_BLEND_ALT)
         && i_pointer_pixel[31:24] == ALPHA_MAX)
        |=> ##2 (o_composed_rgb == $past(i_pointer_pixel[23:0], 3)))
        else $error("opaque blend did not return pointer color");

    // Reset clears the result strobe
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe survived reset");

endmodule

`default_nettype wire

// ===== verif/cursor_pixel_compositor_core_tb.sv =====
// Self-checking testbench for the cursor pixel compositor core.
`timescale 1ns / 100ps

module cursor_pixel_compositor_core_tb;

    import cpc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int N_ROWS       = 20;
    localparam int SEG_ITEMS    = 76;
    localparam int SEGS_PER_PHS = 8;

    // One directed pixel: mode to run in, inputs, and an optional typed-in result
    typedef struct packed {
        t_mode mode;
        t_rgb  desk;
        t_argb ptr;
        logic  and_b;
        logic  xor_b;
        logic  typed;
        t_rgb  want;
    } t_pixel_row;

    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  start           = 1'b0;
    logic  busy;
    t_rgb  i_desktop_rgb   = '0;
    t_argb i_pointer_pixel = '0;
    logic  i_and_bit       = 1'b0;
    logic  i_xor_bit       = 1'b0;
    logic  o_result_valid;
    t_rgb  o_composed_rgb;
    logic  i_cfg_valid     = 1'b0;
    logic  o_cfg_ready;
    t_mode i_cfg_data      = MODE_RESET;

    // Predictor state and scoreboard
    t_mode cur_mode = MODE_RESET;
    t_rgb  composed_q [$];
    t_rgb  head_rgb;
    int    err_cnt     = 0;
    int    n_pixels    = 0;
    int    n_results   = 0;
    int    n_mode_wr   = 0;
    int    mode_hits [4] = '{0, 0, 0, 0};
    int    stall_cycles = 0;

    t_pixel_row directed_rows [N_ROWS] = '{
        // blend mode straight out of reset: alpha extremes and one mid alpha
        '{MODE_BLEND,     24'hFFFFFF, 32'h00000000, 1'b0, 1'b0, 1'b1, 24'hFFFFFF},
        '{MODE_BLEND,     24'h000000, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 24'hFFFFFF},
        '{MODE_BLEND,     24'hFFFFFF, 32'hFF000000, 1'b0, 1'b1, 1'b1, 24'h000000},
        '{MODE_BLEND,     24'h123456, 32'h80ABCDEF, 1'b1, 1'b0, 1'b0, 24'h000000},
        // monochrome: all four mask combinations, pointer ignored
        '{MODE_MONO,      24'hA5C3F0, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1, 24'hA5C3F0},
        '{MODE_MONO,      24'hA5C3F0, 32'h12345678, 1'b0, 1'b0, 1'b1, 24'h000000},
        '{MODE_MONO,      24'hA5C3F0, 32'h00000000, 1'b0, 1'b1, 1'b1, 24'hFFFFFF},
        '{MODE_MONO,      24'hA5C3F0, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 24'h5A3C0F},
        '{MODE_MONO,      24'hFFFFFF, 32'h00000000, 1'b1, 1'b0, 1'b1, 24'hFFFFFF},
        // masked color: zero alpha replaces, other alpha XORs, masks ignored
        '{MODE_MASKED,    24'h123456, 32'h00ABCDEF, 1'b1, 1'b1, 1'b1, 24'hABCDEF},
        '{MODE_MASKED,    24'h123456, 32'h01FFFFFF, 1'b0, 1'b1, 1'b1, 24'hEDCBA9},
        '{MODE_MASKED,    24'hFFFFFF, 32'hFF000000, 1'b1, 1'b0, 1'b1, 24'hFFFFFF},
        '{MODE_MASKED,    24'hFFFFFF, 32'h00000000, 1'b0, 1'b0, 1'b1, 24'h000000},
        '{MODE_MASKED,    24'h0F0F0F, 32'h7F5A5A5A, 1'b1, 1'b1, 1'b0, 24'h000000},
        // unused selector behaves as blend
        '{MODE_BLEND_ALT, 24'h000000, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 24'hFFFFFF},
        '{MODE_BLEND_ALT, 24'h000000, 32'h00FFFFFF, 1'b0, 1'b0, 1'b1, 24'h000000},
        '{MODE_BLEND_ALT, 24'h00FF00, 32'h01FF00FF, 1'b1, 1'b0, 1'b0, 24'h000000},
        '{MODE_BLEND_ALT, 24'h7F7F7F, 32'hFE808080, 1'b0, 1'b1, 1'b0, 24'h000000},
        // back to blend: rounding around half alpha
        '{MODE_BLEND,     24'h0000FF, 32'h80FF0000, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{MODE_BLEND,     24'hFFFFFF, 32'h7F000000, 1'b1, 1'b1, 1'b0, 24'h000000}
    };

    cursor_pixel_compositor_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_desktop_rgb   (i_desktop_rgb),
        .i_pointer_pixel (i_pointer_pixel),
        .i_and_bit       (i_and_bit),
        .i_xor_bit       (i_xor_bit),
        .o_result_valid  (o_result_valid),
        .o_composed_rgb  (o_composed_rgb),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Blend one channel with rounding: (fg*a + bg*(255-a) + 127) / 255
    function automatic t_chan mix_channel(input t_chan fg, input t_chan bg, input t_chan alpha);
        logic [16:0] acc;
        acc = 17'(fg) * 17'(alpha) + 17'(bg) * 17'(ALPHA_MAX - alpha) + 17'(ROUND_BIAS);
        return t_chan'(acc / 17'd255);
    endfunction

    // Compose one desktop pixel with the pointer data under the given mode
    function automatic t_rgb compose_pixel(input t_mode mode, input t_rgb desk, input t_argb ptr,
                                           input logic and_b, input logic xor_b);
        t_rgb  res;
        t_chan alpha;
        alpha = ptr[31:24];
        res   = '0;
        case (mode)
            MODE_MONO: begin
                res = (desk & {24{and_b}}) ^ {24{xor_b}};
            end
            MODE_MASKED: begin
                res = (alpha == 8'd0) ? ptr[23:0] : (desk ^ ptr[23:0]);
            end
            default: begin
                for (int c = 0; c < 3; c++)
                    res[c*8 +: 8] = mix_channel(ptr[c*8 +: 8], desk[c*8 +: 8], alpha);
            end
        endcase
        return res;
    endfunction

    // Present one pixel transaction and hold it until accepted
    task automatic send_pixel(input t_rgb desk, input t_argb ptr, input logic and_b,
                              input logic xor_b, input logic typed, input t_rgb want);
        start           <= 1'b1;
        i_desktop_rgb   <= desk;
        i_pointer_pixel <= ptr;
        i_and_bit       <= and_b;
        i_xor_bit       <= xor_b;
        do @(posedge i_clk); while (busy);
        composed_q.push_back(typed ? want : compose_pixel(cur_mode, desk, ptr, and_b, xor_b));
        n_pixels++;
        mode_hits[cur_mode]++;
    endtask

    // Idle the sender for a random number of cycles, with noise on the data
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start           <= 1'b0;
            i_desktop_rgb   <= t_rgb'($urandom);
            i_pointer_pixel <= $urandom;
            i_and_bit       <= 1'($urandom);
            i_xor_bit       <= 1'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        while (composed_q.size() != 0) @(posedge i_clk);
    endtask

    // Write the shape mode register through its handshake
    task automatic write_mode(input t_mode m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = m;
        n_mode_wr++;
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (composed_q.size() == 0) begin
                $error("composed_rgb with nothing pending: actual %h", o_composed_rgb);
                err_cnt++;
            end else begin
                head_rgb = composed_q.pop_front();
                if (o_composed_rgb !== head_rgb) begin
                    $error("composed_rgb mismatch: expected %h, actual %h",
                           head_rgb, o_composed_rgb);
                    err_cnt++;
                end
            end
        end
    end

    // Abort when no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Main stimulus
    initial begin : stimulus
        t_rgb  desk;
        t_argb ptr;
        t_chan alpha;
        t_mode seg_mode;
        int    pct;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table, switching mode only while idle
        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].mode != cur_mode) begin
                drain_results();
                write_mode(directed_rows[r].mode);
            end
            send_pixel(directed_rows[r].desk, directed_rows[r].ptr, directed_rows[r].and_b,
                       directed_rows[r].xor_b, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random phases: moderate sender gaps, heavy gaps, then back to back
        for (int phs = 0; phs < 3; phs++) begin
            pct = (phs == 0) ? 27 : (phs == 1) ? 74 : 0;
            for (int seg = 0; seg < SEGS_PER_PHS; seg++) begin
                seg_mode = (seg < 4) ? t_mode'(seg) : t_mode'($urandom_range(3));
                drain_results();
                write_mode(seg_mode);
                for (int k = 0; k < SEG_ITEMS; k++) begin
                    case ($urandom_range(7))
                        0:       desk = 24'h000000;
                        1:       desk = 24'hFFFFFF;
                        default: desk = t_rgb'($urandom);
                    endcase
                    case ($urandom_range(7))
                        0:       alpha = 8'h00;
                        1:       alpha = 8'hFF;
                        2:       alpha = 8'h01;
                        3:       alpha = 8'hFE;
                        default: alpha = t_chan'($urandom);
                    endcase
                    case ($urandom_range(5))
                        0:       ptr = {alpha, 24'h000000};
                        1:       ptr = {alpha, 24'hFFFFFF};
                        default: ptr = {alpha, 24'($urandom)};
                    endcase
                    idle_gap(pct);
                    send_pixel(desk, ptr, 1'($urandom), 1'($urandom), 1'b0, '0);
                end
            end
        end

        // Let the pipeline empty, then idle before checking for missing results
        drain_results();
        repeat (8) @(posedge i_clk);
        if (composed_q.size() != 0) begin
            $error("%0d composed_rgb results never arrived", composed_q.size());
            err_cnt++;
        end

        $display("Composed %0d pixels: mono %0d, masked %0d, blend %0d, alt blend %0d",
                 n_pixels, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        $display("Checked %0d results across %0d mode writes, %0d mismatches",
                 n_results, n_mode_wr, err_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
